[hdl/mtwa_pkg.sv]
// Shared types and constants of the microsecond ticker with alarm.
// Operation codes, queued command format, payload structs, status struct.
// No dependencies.
package mtwa_pkg;

	localparam int unsigned QueueDepth = 2;
	localparam int unsigned DivSteps   = 40;

	localparam logic [2:0] OP_TICK      = 3'd0;
	localparam logic [2:0] OP_READ      = 3'd1;
	localparam logic [2:0] OP_SET_ALARM = 3'd2;
	localparam logic [2:0] OP_DISABLE   = 3'd3;
	localparam logic [2:0] OP_CLEAR     = 3'd4;

	localparam logic [23:0] HIGH_RESET  = 24'h02ff00;
	localparam logic [15:0] HALF_PERIOD = 16'h8000;
	localparam logic [7:0]  TICKS_RESET = 8'd1;

	typedef enum logic [2:0] {
		CMD_TICK,
		CMD_READ,
		CMD_SET_ALARM,
		CMD_DISABLE,
		CMD_CLEAR,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] alarm_time_us;
	} in_item_t;

	typedef struct packed {
		logic [31:0] time_us;
		logic        alarm_line;
	} out_item_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [31:0] alarm_time_us;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

	typedef struct packed {
		logic alarm_enabled;
		logic busy;
		logic div_busy;
	} back_status_t;

endpackage

[hdl/mtwa_front.sv]
// Front end: accepts input beats, decodes the operation and queues commands.
// Depends on mtwa_pkg.
module mtwa_front #(
	parameter int unsigned DEPTH = mtwa_pkg::QueueDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mtwa_pkg::in_item_t in_data,
	output mtwa_pkg::q_head_t  head,
	input  logic               pop
);
	import mtwa_pkg::*;

	localparam int unsigned IdxW = $clog2(DEPTH);
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	cmd_t            queue_q [DEPTH];
	logic [IdxW-1:0] wr_q;
	logic [IdxW-1:0] rd_q;
	logic [CntW-1:0] cnt_q;
	cmd_t            cmd_in;
	logic            push;

	always_comb begin
		cmd_in.alarm_time_us = in_data.alarm_time_us;
		case (in_data.operation)
			OP_TICK:      cmd_in.kind = CMD_TICK;
			OP_READ:      cmd_in.kind = CMD_READ;
			OP_SET_ALARM: cmd_in.kind = CMD_SET_ALARM;
			OP_DISABLE:   cmd_in.kind = CMD_DISABLE;
			OP_CLEAR:     cmd_in.kind = CMD_CLEAR;
			default:      cmd_in.kind = CMD_NOP;
		endcase
	end

	assign in_ready   = (cnt_q != CntW'(DEPTH));
	assign push       = in_valid && in_ready;
	assign head.valid = (cnt_q != '0);
	assign head.cmd   = queue_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == IdxW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == IdxW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[hdl/mtwa_div.sv]
// Restoring divider, one quotient bit per cycle: 40-bit count by 8-bit divisor.
// Depends on mtwa_pkg.
module mtwa_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [39:0] dividend,
	input  logic [7:0]  divisor,
	output logic        busy,
	output logic        done,
	output logic [31:0] quotient
);
	import mtwa_pkg::*;

	localparam int unsigned CntW = $clog2(DivSteps);

	logic [7:0]      rem_q;
	logic [39:0]     quo_q;
	logic [7:0]      dvs_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [8:0]      trial;
	logic [8:0]      diff;
	logic            ge;

	assign trial    = {rem_q, quo_q[39]};
	assign ge       = (trial >= {1'b0, dvs_q});
	assign diff     = trial - {1'b0, dvs_q};
	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q[31:0];

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[7:0] : trial[7:0];
			quo_q <= {quo_q[38:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CntW'(DivSteps - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

[hdl/mtwa_back.sv]
// Back end: counter, alarm state, command sequencer and output register.
// Depends on mtwa_pkg and mtwa_div.
module mtwa_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [7:0]             cfg_data,
	input  mtwa_pkg::q_head_t      head,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output mtwa_pkg::out_item_t    out_data,
	output mtwa_pkg::back_status_t status
);
	import mtwa_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_SET,
		ST_READ
	} state_t;

	state_t      state_q;
	logic [7:0]  ticks_q;
	logic [15:0] low_q;
	logic [23:0] high_q;
	logic [15:0] cmp_q;
	logic [15:0] crem_q;
	logic [31:0] wraps_q;
	logic        flag_q;
	logic        en_q;
	logic        is_read_q;
	logic [31:0] target_q;
	logic [31:0] dist_ticks_q;
	logic [15:0] tgt_ticks_q;
	logic        out_valid_q;
	out_item_t   out_data_q;

	logic [7:0]  eff_t;
	logic        out_free;
	logic        res_load;
	logic        cur_alarm;
	logic        div_start;
	logic        div_busy;
	logic        div_done;
	logic [31:0] now_us;

	// tick next state
	logic [15:0] low_n;
	logic [23:0] high_inc;
	logic [23:0] high_n;
	logic        flag_a;
	logic [15:0] cmp_n;
	logic [15:0] crem_n;
	logic [31:0] wraps_n;
	logic        flag_n;
	logic        tick_alarm;

	// set alarm arithmetic
	logic [31:0] diff;
	logic        short_dist;
	logic [31:0] dist_us;
	logic [39:0] dist_prod;
	logic [23:0] tgt_prod;
	logic [31:0] wraps_full;
	logic        use_half;

	assign eff_t     = (ticks_q == '0) ? 8'd1 : ticks_q;
	assign out_free  = !out_valid_q || out_ready;
	assign cur_alarm = flag_q && en_q && (crem_q == '0) && (wraps_q == '0);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign status.alarm_enabled = en_q;
	assign status.busy          = (state_q != ST_IDLE);
	assign status.div_busy      = div_busy;

	always_comb begin
		pop = 1'b0;
		if (state_q == ST_IDLE && head.valid) begin
			case (head.cmd.kind)
				CMD_READ, CMD_SET_ALARM: pop = 1'b1;
				default:                 pop = out_free;
			endcase
		end
	end

	assign div_start = pop && (head.cmd.kind == CMD_READ || head.cmd.kind == CMD_SET_ALARM);
	assign res_load  = (pop && !div_start) ||
		((state_q == ST_SET || state_q == ST_READ) && out_free);

	mtwa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({high_q, low_q}),
		.divisor  (eff_t),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (now_us)
	);

	always_comb begin
		low_n    = low_q + 16'd1;
		high_inc = high_q + 24'd1;
		high_n   = high_q;
		if (low_n == '0) begin
			high_n = (high_inc >= {eff_t, 16'h0000}) ? '0 : high_inc;
		end
		flag_a  = flag_q || (low_n == cmp_q);
		cmp_n   = cmp_q;
		crem_n  = crem_q;
		wraps_n = wraps_q;
		flag_n  = flag_a;
		if (flag_a && en_q) begin
			if (crem_q != '0) begin
				cmp_n  = crem_q;
				crem_n = '0;
				flag_n = 1'b0;
			end else if (wraps_q != '0) begin
				wraps_n = wraps_q - 32'd1;
				flag_n  = 1'b0;
			end
		end
		tick_alarm = flag_n && en_q && (crem_n == '0) && (wraps_n == '0);
	end

	always_comb begin
		diff       = target_q - now_us;
		short_dist = diff[31] || (diff <= {24'd0, eff_t});
		dist_us    = short_dist ? {24'd0, eff_t} : diff;
		dist_prod  = dist_us * eff_t;
		tgt_prod   = target_q[15:0] * eff_t;
		wraps_full = {16'd0, dist_ticks_q[31:16]};
		use_half   = !dist_ticks_q[15] && (wraps_full != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ticks_q      <= TICKS_RESET;
			low_q        <= '0;
			high_q       <= HIGH_RESET;
			cmp_q        <= '0;
			crem_q       <= '0;
			wraps_q      <= '0;
			flag_q       <= 1'b0;
			en_q         <= 1'b0;
			is_read_q    <= 1'b0;
			target_q     <= '0;
			dist_ticks_q <= '0;
			tgt_ticks_q  <= '0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
		end else begin
			if (cfg_valid) begin
				ticks_q <= cfg_data;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (head.cmd.kind)
							CMD_TICK: begin
								low_q      <= low_n;
								high_q     <= high_n;
								cmp_q      <= cmp_n;
								crem_q     <= crem_n;
								wraps_q    <= wraps_n;
								flag_q     <= flag_n;
								out_data_q <= '{time_us: '0, alarm_line: tick_alarm};
							end
							CMD_READ, CMD_SET_ALARM: begin
								is_read_q <= (head.cmd.kind == CMD_READ);
								target_q  <= head.cmd.alarm_time_us;
								state_q   <= ST_DIV;
							end
							CMD_DISABLE: begin
								en_q       <= 1'b0;
								out_data_q <= '{time_us: '0, alarm_line: 1'b0};
							end
							CMD_CLEAR: begin
								flag_q     <= 1'b0;
								out_data_q <= '{time_us: '0, alarm_line: 1'b0};
							end
							default: begin
								out_data_q <= '{time_us: '0, alarm_line: cur_alarm};
							end
						endcase
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= is_read_q ? ST_READ : ST_MUL;
					end
				end
				ST_MUL: begin
					dist_ticks_q <= dist_prod[31:0];
					tgt_ticks_q  <= tgt_prod[15:0];
					state_q      <= ST_SET;
				end
				ST_SET: begin
					if (out_free) begin
						if (use_half) begin
							cmp_q   <= tgt_ticks_q + HALF_PERIOD;
							crem_q  <= tgt_ticks_q;
							wraps_q <= wraps_full - 32'd1;
						end else begin
							cmp_q   <= tgt_ticks_q;
							crem_q  <= '0;
							wraps_q <= wraps_full;
						end
						flag_q     <= 1'b0;
						en_q       <= 1'b1;
						out_data_q <= '{time_us: '0, alarm_line: 1'b0};
						state_q    <= ST_IDLE;
					end
				end
				ST_READ: begin
					if (out_free) begin
						out_data_q <= '{time_us: now_us, alarm_line: cur_alarm};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[hdl/microsecond_ticker_with_alarm.sv]
// Top level of the microsecond ticker with alarm: front queue plus back end.
// Depends on mtwa_pkg, mtwa_front, mtwa_back (which holds mtwa_div).
//
// Each input beat gives exactly one output beat, in order. Tick, disable,
// clear and unused operations can follow one another every cycle while no
// read or set alarm is in progress and the output is not held back. Read
// time divides the 40-bit tick count by ticks_per_us in a divider that
// produces one quotient bit per cycle, and set alarm adds a multiply step
// after it. A command queue of QUEUE_DEPTH entries in front keeps accepting
// beats while a read or set alarm is in progress, until it is full, and the
// output register holds a result while the next one is computed. ticks_per_us
// may be written only while the block is idle; a value of zero acts as one.
module microsecond_ticker_with_alarm #(
	parameter int unsigned QUEUE_DEPTH = mtwa_pkg::QueueDepth
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  mtwa_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output mtwa_pkg::out_item_t out_data
);
	import mtwa_pkg::*;

	q_head_t      head;
	logic         pop;
	back_status_t status;

	mtwa_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.head     (head),
		.pop      (pop)
	);

	mtwa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.status    (status)
	);

	// a raised alarm beat is only ever produced with the alarm enabled
	a_alarm_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.alarm_line |-> status.alarm_enabled)
		else $error("alarm_line high with alarm disabled");

	a_div_in_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_busy |-> status.busy)
		else $error("divider running outside a read or set alarm");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("command popped from empty queue");

endmodule
